[rtl/core/rrc_pkg.sv]
// ----------------------------------------------------------------------------
// rrc_pkg
// Shared types, constants and the victim-selection lfsr step for the
// random replacement cache.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rrc_pkg;

	localparam int LFSR_W = 16;
	localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;
	localparam logic [LFSR_W-1:0] SEED_RESET = 16'd44257;
	localparam logic [LFSR_W-1:0] SEED_ZERO_SUB = 16'd1;

	localparam int COUNT_W = 32;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	// flags of the lookup token walking down the cell chain
	typedef struct packed {
		logic active;
		logic found;
		logic vic_valid;
	} tok_ctl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MOD,
		ST_SWEEP
	} state_t;

	// one right-shifting galois step
	function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] cur);
		logic [LFSR_W-1:0] nxt;
		nxt = cur >> 1;
		if (cur[0]) begin
			nxt = nxt ^ LFSR_TAPS;
		end
		return nxt;
	endfunction

	// a zero seed would lock the lfsr
	function automatic logic [LFSR_W-1:0] lfsr_load(input logic [LFSR_W-1:0] seed);
		return (seed == '0) ? SEED_ZERO_SUB : seed;
	endfunction

	function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c);
		return (c == COUNT_MAX) ? c : c + COUNT_W'(1);
	endfunction

endpackage

`default_nettype wire

[rtl/core/rrc_cell.sv]
// ----------------------------------------------------------------------------
// rrc_cell
// One cache slot: holds key, value and valid, and updates the lookup token
// as it passes on to the next cell.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rrc_cell import rrc_pkg::*; #(
	parameter int ENTRIES    = 16,
	parameter int KEY_BITS   = 16,
	parameter int VALUE_BITS = 32,
	parameter int IDX        = 0
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire  [KEY_BITS-1:0]         key,
	input  wire  [$clog2(ENTRIES)-1:0]  victim,
	input  wire                         wr_en,
	input  wire  [KEY_BITS-1:0]         wr_key,
	input  wire  [VALUE_BITS-1:0]       wr_value,
	input  wire tok_ctl_t               ctl_in,
	input  wire  [VALUE_BITS-1:0]       value_in,
	input  wire  [$clog2(ENTRIES)-1:0]  slot_in,
	input  wire  [KEY_BITS-1:0]         vkey_in,
	output tok_ctl_t                    ctl_out,
	output logic [VALUE_BITS-1:0]       value_out,
	output logic [$clog2(ENTRIES)-1:0]  slot_out,
	output logic [KEY_BITS-1:0]         vkey_out
);

	localparam int SLOT_W = $clog2(ENTRIES);
	localparam logic [SLOT_W-1:0] MY_SLOT = SLOT_W'(IDX);

	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] value_q;
	logic                  valid_q;

	tok_ctl_t              tok_ctl_q;
	logic [VALUE_BITS-1:0] tok_value_q;
	logic [SLOT_W-1:0]     tok_slot_q;
	logic [KEY_BITS-1:0]   tok_vkey_q;

	logic match;
	logic at_victim;

	assign match     = valid_q && (key_q == key);
	assign at_victim = (victim == MY_SLOT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (wr_en) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_q   <= wr_key;
			value_q <= wr_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_ctl_q <= '0;
		end else begin
			tok_ctl_q.active    <= ctl_in.active;
			tok_ctl_q.found     <= ctl_in.found | match;
			tok_ctl_q.vic_valid <= at_victim ? valid_q : ctl_in.vic_valid;
		end
	end

	// first match wins, later cells pass it through
	always_ff @(posedge clk) begin
		if (!ctl_in.found && match) begin
			tok_value_q <= value_q;
			tok_slot_q  <= MY_SLOT;
		end else begin
			tok_value_q <= value_in;
			tok_slot_q  <= slot_in;
		end
		tok_vkey_q <= at_victim ? key_q : vkey_in;
	end

	assign ctl_out   = tok_ctl_q;
	assign value_out = tok_value_q;
	assign slot_out  = tok_slot_q;
	assign vkey_out  = tok_vkey_q;

endmodule

`default_nettype wire

[rtl/core/rrc_mod.sv]
// ----------------------------------------------------------------------------
// rrc_mod
// Remainder of the lfsr word by the slot count, by reciprocal multiplication.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rrc_mod import rrc_pkg::*; #(
	parameter int ENTRIES = 16
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         start,
	input  wire  [LFSR_W-1:0]           x,
	output logic                        done,
	output logic [$clog2(ENTRIES)-1:0]  rem
);

	localparam int SLOT_W  = $clog2(ENTRIES);
	localparam int SHIFT   = LFSR_W + SLOT_W;
	localparam int RECIP_W = LFSR_W + 1;
	localparam int PROD_W  = LFSR_W + RECIP_W;
	// ceil(2^SHIFT / ENTRIES) gives the exact quotient for every lfsr word
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((1 << SHIFT) + ENTRIES - 1) / ENTRIES);
	localparam logic [LFSR_W-1:0]  DIV   = LFSR_W'(ENTRIES);

	logic [LFSR_W-1:0] x_s1;
	logic              run_s1;
	logic [LFSR_W-1:0] x_s2;
	logic [LFSR_W-1:0] quo_s2;
	logic              run_s2;
	logic [SLOT_W-1:0] rem_q;
	logic              done_q;

	logic [PROD_W-1:0] prod;
	logic [LFSR_W-1:0] quo;
	logic [LFSR_W-1:0] back;
	logic [LFSR_W-1:0] diff;

	assign prod = PROD_W'(x_s1) * PROD_W'(RECIP);
	assign quo  = LFSR_W'(prod >> SHIFT);
	assign back = quo_s2 * DIV;
	assign diff = x_s2 - back;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_s1 <= 1'b0;
			run_s2 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			run_s1 <= start;
			run_s2 <= run_s1;
			done_q <= run_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_s1 <= x;
		end
		if (run_s1) begin
			x_s2   <= x_s1;
			quo_s2 <= quo;
		end
		if (run_s2) begin
			rem_q <= diff[SLOT_W-1:0];
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

`default_nettype wire

[rtl/core/random_replacement_cache.sv]
// ----------------------------------------------------------------------------
// random_replacement_cache
// Fully associative cache with lfsr-driven random replacement and saturating
// request, hit and eviction counters.
// ----------------------------------------------------------------------------
//  channel   | handshake            | payload
//  ----------+----------------------+------------------------------------------
//  request   | start / busy         | lookup_key, fill_value
//  result    | done (one cycle)     | read_value, was_hit, did_evict,
//            |                      | evicted_key, slot_used, total_*
//  seed      | seed_we              | seed_wdata
//
//  A request is taken when start is high and busy low. The strobe rises
//  after the remainder that picks the victim slot (run_s1, run_s2 and
//  done_q in rrc_mod), the walk of the lookup token through the slot
//  chain, one register per cell, and the result register. busy drops with
//  the strobe, so the next request can be taken in the strobe cycle. Reset
//  clears all valid bits at once and loads the seed default into the lfsr;
//  the receiver cannot stall results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module random_replacement_cache import rrc_pkg::*; #(
	parameter int ENTRIES    = 16,
	parameter int KEY_BITS   = 16,
	parameter int VALUE_BITS = 32
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         start,
	output logic                        busy,
	input  wire  [KEY_BITS-1:0]         lookup_key,
	input  wire  [VALUE_BITS-1:0]       fill_value,
	input  wire                         seed_we,
	input  wire  [LFSR_W-1:0]           seed_wdata,
	output logic                        done,
	output logic [VALUE_BITS-1:0]       read_value,
	output logic                        was_hit,
	output logic                        did_evict,
	output logic [KEY_BITS-1:0]         evicted_key,
	output logic [$clog2(ENTRIES)-1:0]  slot_used,
	output logic [COUNT_W-1:0]          total_requests,
	output logic [COUNT_W-1:0]          total_hits,
	output logic [COUNT_W-1:0]          total_misses,
	output logic [COUNT_W-1:0]          total_evictions
);

	localparam int SLOT_W = $clog2(ENTRIES);

	state_t state_q, state_nx;
	logic   inj;
	logic   accept;
	logic   last;
	logic   hit;
	logic   evict;

	logic [LFSR_W-1:0]     lfsr_q;
	logic [LFSR_W-1:0]     lfsr_nx_q;
	logic [KEY_BITS-1:0]   req_key_q;
	logic [VALUE_BITS-1:0] req_fill_q;

	logic [COUNT_W-1:0] req_cnt_q;
	logic [COUNT_W-1:0] hit_cnt_q;
	logic [COUNT_W-1:0] evict_cnt_q;

	logic                  done_q;
	logic [VALUE_BITS-1:0] read_value_q;
	logic                  was_hit_q;
	logic                  did_evict_q;
	logic [KEY_BITS-1:0]   evicted_key_q;
	logic [SLOT_W-1:0]     slot_used_q;

	logic              mod_done;
	logic [SLOT_W-1:0] victim;

	tok_ctl_t              ctl_w   [ENTRIES+1];
	logic [VALUE_BITS-1:0] value_w [ENTRIES+1];
	logic [SLOT_W-1:0]     slot_w  [ENTRIES+1];
	logic [KEY_BITS-1:0]   vkey_w  [ENTRIES+1];
	logic [ENTRIES-1:0]    wr_en;

	assign accept = start && !busy;

	// fsm
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		inj      = 1'b0;
		busy     = 1'b1;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					state_nx = ST_MOD;
				end
			end
			ST_MOD: begin
				if (mod_done) begin
					inj      = 1'b1;
					state_nx = ST_SWEEP;
				end
			end
			ST_SWEEP: begin
				if (last) begin
					state_nx = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	// victim slot = next lfsr value mod ENTRIES
	rrc_mod #(
		.ENTRIES (ENTRIES)
	) u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.x      (lfsr_step(lfsr_q)),
		.done   (mod_done),
		.rem    (victim)
	);

	// token enters at cell 0
	assign ctl_w[0]   = '{active: inj, found: 1'b0, vic_valid: 1'b0};
	assign value_w[0] = '0;
	assign slot_w[0]  = '0;
	assign vkey_w[0]  = '0;

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		assign wr_en[i] = last && !hit && (victim == SLOT_W'(i));

		rrc_cell #(
			.ENTRIES    (ENTRIES),
			.KEY_BITS   (KEY_BITS),
			.VALUE_BITS (VALUE_BITS),
			.IDX        (i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.key       (req_key_q),
			.victim    (victim),
			.wr_en     (wr_en[i]),
			.wr_key    (req_key_q),
			.wr_value  (req_fill_q),
			.ctl_in    (ctl_w[i]),
			.value_in  (value_w[i]),
			.slot_in   (slot_w[i]),
			.vkey_in   (vkey_w[i]),
			.ctl_out   (ctl_w[i+1]),
			.value_out (value_w[i+1]),
			.slot_out  (slot_w[i+1]),
			.vkey_out  (vkey_w[i+1])
		);
	end

	assign last  = ctl_w[ENTRIES].active;
	assign hit   = ctl_w[ENTRIES].found;
	assign evict = !hit && ctl_w[ENTRIES].vic_valid;

	always_ff @(posedge clk) begin
		if (accept) begin
			req_key_q  <= lookup_key;
			req_fill_q <= fill_value;
			lfsr_nx_q  <= lfsr_step(lfsr_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lfsr_q      <= SEED_RESET;
			req_cnt_q   <= '0;
			hit_cnt_q   <= '0;
			evict_cnt_q <= '0;
			done_q      <= 1'b0;
		end else begin
			done_q <= last;
			if (seed_we) begin
				lfsr_q <= lfsr_load(seed_wdata);
			end else if (last && !hit) begin
				lfsr_q <= lfsr_nx_q;
			end
			if (last) begin
				req_cnt_q <= sat_inc(req_cnt_q);
				if (hit) begin
					hit_cnt_q <= sat_inc(hit_cnt_q);
				end
				if (evict) begin
					evict_cnt_q <= sat_inc(evict_cnt_q);
				end
			end
		end
	end

	// result beat
	always_ff @(posedge clk) begin
		if (last) begin
			read_value_q  <= hit ? value_w[ENTRIES] : req_fill_q;
			was_hit_q     <= hit;
			did_evict_q   <= evict;
			evicted_key_q <= evict ? vkey_w[ENTRIES] : '0;
			slot_used_q   <= hit ? slot_w[ENTRIES] : victim;
		end
	end

	assign done            = done_q;
	assign read_value      = read_value_q;
	assign was_hit         = was_hit_q;
	assign did_evict       = did_evict_q;
	assign evicted_key     = evicted_key_q;
	assign slot_used       = slot_used_q;
	assign total_requests  = req_cnt_q;
	assign total_hits      = hit_cnt_q;
	assign total_misses    = req_cnt_q - hit_cnt_q;
	assign total_evictions = evict_cnt_q;

	a_single_beat: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result strobe held for more than one cycle");

	a_lfsr_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		lfsr_q != '0)
		else $error("victim lfsr locked at zero");

	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && was_hit_q) |-> !did_evict_q)
		else $error("eviction reported on a hit");

	a_hits_le_reqs: assert property (@(posedge clk) disable iff (!arst_n)
		hit_cnt_q <= req_cnt_q)
		else $error("hit count above request count");

	a_busy_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		last |-> (state_q == ST_SWEEP))
		else $error("token left the chain outside a sweep");

endmodule

`default_nettype wire
